[rtl/core/sha_pkg.sv]
package sha_pkg;

  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned ROUNDS     = 64;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[rtl/core/sha_in_if.sv]
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       final_item;

  modport source (output valid, output data_byte, output byte_present, output final_item,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input final_item,
                output ready);
endinterface

[rtl/core/sha_out_if.sv]
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

[rtl/core/sha256_hash_core.sv]
// Channel     Direction  Transaction
// data_in     in         one message byte (optional) and the final mark
// digest_out  out        one 32-bit digest word, index and last mark
//
// Each message byte is shifted into the block buffer; every full 64-byte block then
// passes the shared round unit (64 rounds, one chaining add) before more bytes are taken.
// A final transaction adds padding and length bytes (up to 72), shifted in one by one,
// plus one or two compressions, then eight digest words from an output register.
// Reset is synchronous; data_in is ready only while waiting for a byte.
// A stalled digest_out holds the core in its output phase.
module sha256_hash_core (
  input  logic      clk,
  input  logic      rst,
  sha_in_if.sink    data_in,
  sha_out_if.source digest_out
);
  import sha_pkg::*;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]            state;
  logic [BLOCK_BITS-1:0] blk;
  logic [31:0]           chain [8];
  logic [31:0]           v [8];
  logic [5:0]            rnd;
  logic [5:0]            fill;
  logic [60:0]           byte_count;
  logic [63:0]           len_sh;
  logic                  pad_first;
  logic                  zero_blk;
  logic                  padding;
  logic                  last_blk;
  logic [2:0]            oidx;
  logic                  ovalid;
  logic [31:0]           oword;
  logic [2:0]            oindex;
  logic                  olast;

  logic        accept;
  logic [5:0]  fill_next;
  logic [60:0] byte_count_next;
  logic        len_byte;
  logic [7:0]  pad_byte;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  assign data_in.ready          = (state == ST_LOAD);
  assign accept                 = data_in.valid && data_in.ready;
  assign digest_out.valid       = ovalid;
  assign digest_out.digest_word = oword;
  assign digest_out.word_index  = oindex;
  assign digest_out.last_word   = olast;

  always_comb begin
    fill_next       = data_in.byte_present ? fill + 6'd1 : fill;
    byte_count_next = data_in.byte_present ? byte_count + 61'd1 : byte_count;
    len_byte        = !pad_first && !zero_blk && (fill[5:3] == 3'b111);
    if (pad_first) begin
      pad_byte = PAD_BYTE;
    end else if (len_byte) begin
      pad_byte = len_sh[63:56];
    end else begin
      pad_byte = 8'h00;
    end
    t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd]
         + blk[511:480];
    t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = blk[511:480] + small_sigma0(blk[479:448]) + blk[223:192]
            + small_sigma1(blk[63:32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      chain      <= INIT_CHAIN;
      rnd        <= '0;
      fill       <= '0;
      byte_count <= '0;
      pad_first  <= 1'b0;
      zero_blk   <= 1'b0;
      padding    <= 1'b0;
      last_blk   <= 1'b0;
      oidx       <= '0;
      ovalid     <= 1'b0;
    end else begin
      if (digest_out.ready && (state != ST_OUT)) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (data_in.byte_present) begin
              blk        <= {blk[BLOCK_BITS-9:0], data_in.data_byte};
              fill       <= fill_next;
              byte_count <= byte_count_next;
            end
            if (data_in.final_item) begin
              padding   <= 1'b1;
              pad_first <= 1'b1;
              last_blk  <= 1'b0;
              len_sh    <= {byte_count_next, 3'b000};
              zero_blk  <= (fill_next[5:3] == 3'b111);
            end
            if (data_in.byte_present && fill == 6'd63) begin
              v     <= chain;
              rnd   <= '0;
              state <= ST_COMP;
            end else if (data_in.final_item) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          blk       <= {blk[BLOCK_BITS-9:0], pad_byte};
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          if (len_byte) begin
            len_sh <= {len_sh[55:0], 8'h00};
          end
          if (fill == 6'd63) begin
            v     <= chain;
            rnd   <= '0;
            state <= ST_COMP;
            if (zero_blk) begin
              zero_blk <= 1'b0;
            end else begin
              last_blk <= 1'b1;
            end
          end
        end
        ST_COMP: begin
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          blk  <= {blk[BLOCK_BITS-33:0], w_new};
          rnd  <= rnd + 6'd1;
          if (rnd == 6'(ROUNDS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          oidx <= '0;
          if (last_blk) begin
            state <= ST_OUT;
          end else if (padding) begin
            state <= ST_PAD;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (!ovalid || digest_out.ready) begin
            ovalid <= 1'b1;
            oword  <= chain[oidx];
            oindex <= oidx;
            olast  <= (oidx == 3'd7);
            oidx   <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              chain      <= INIT_CHAIN;
              byte_count <= '0;
              fill       <= '0;
              padding    <= 1'b0;
              last_blk   <= 1'b0;
              state      <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
